[rtl/bji_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bji_pkg - shared types and constants of the box jitter injector
// coordinate format, config register map, multiplier operand widths
// ----------------------------------------------------------------------------
package bji_pkg;

	// coordinates, 1/16 px two's complement
	localparam int COORD_BITS = 17;
	typedef logic signed [COORD_BITS-1:0] coord_t;

	// config write port
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_JITTER_ON  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_AMP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_AMP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED = 3'd4;

	// noise generator
	localparam int GEN_W     = 32;
	localparam int DRAW_BITS = 24;
	localparam int DRAW_W    = DRAW_BITS + 1;

	// shared multiplier operands
	localparam int MUL_A_W = (COORD_BITS + 1 > DRAW_W) ? COORD_BITS + 1 : DRAW_W;
	localparam int MUL_B_W = 18;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	typedef struct packed {
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
		logic                      acc;
	} mac_op_t;

endpackage

`default_nettype wire

[rtl/bji_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bji_if - box channels of the jitter injector
// valid/ready channels carrying one bounding box per transaction
// ----------------------------------------------------------------------------
interface bji_in_if;
	import bji_pkg::*;

	logic   valid;
	logic   ready;
	coord_t in_left;
	coord_t in_right;
	coord_t in_top;
	coord_t in_bottom;
	logic   in_visible;

	modport source (output valid, in_left, in_right, in_top, in_bottom, in_visible,
		input ready);
	modport sink (input valid, in_left, in_right, in_top, in_bottom, in_visible,
		output ready);
endinterface

interface bji_out_if;
	import bji_pkg::*;

	logic   valid;
	logic   ready;
	coord_t out_left;
	coord_t out_right;
	coord_t out_top;
	coord_t out_bottom;
	logic   out_visible;

	modport source (output valid, out_left, out_right, out_top, out_bottom, out_visible,
		input ready);
	modport sink (input valid, out_left, out_right, out_top, out_bottom, out_visible,
		output ready);
endinterface

`default_nettype wire

[rtl/bji_rng.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bji_rng - xorshift32 noise generator
// one draw per step, mapped to a signed value in (-2^24, 2^24)
// ----------------------------------------------------------------------------
module bji_rng (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                load,
	input  wire logic [bji_pkg::GEN_W-1:0]           seed,
	input  wire logic                                step,
	output logic signed [bji_pkg::DRAW_W-1:0]        draw,
	output logic [bji_pkg::GEN_W-1:0]                gen
);
	import bji_pkg::*;

	localparam int SHL_A = 13;
	localparam int SHR_B = 17;
	localparam int SHL_C = 5;
	localparam logic [DRAW_BITS-1:0] DRAW_MASK = '1;

	logic [GEN_W-1:0]        gen_q;
	logic [GEN_W-1:0]        x1;
	logic [GEN_W-1:0]        x2;
	logic [GEN_W-1:0]        gen_next;
	logic signed [DRAW_W:0]  wide;

	always_comb begin
		x1       = gen_q ^ (gen_q << SHL_A);
		x2       = x1 ^ (x1 >> SHR_B);
		gen_next = x2 ^ (x2 << SHL_C);
		// 2r - (2^24 - 1)
		wide     = $signed({1'b0, gen_next[DRAW_BITS-1:0], 1'b0})
			- $signed({2'b00, DRAW_MASK});
	end

	assign draw = wide[DRAW_W-1:0];
	assign gen  = gen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= GEN_W'(1);
		end else if (load) begin
			gen_q <= seed;
		end else if (step) begin
			gen_q <= gen_next;
		end
	end
endmodule

`default_nettype wire

[rtl/bji_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bji_mul - shared signed multiply-accumulate unit
// registered product, optionally added to the previous one
// ----------------------------------------------------------------------------
module bji_mul (
	input  wire logic                               clk,
	input  wire bji_pkg::mac_op_t                   op,
	output logic signed [bji_pkg::PROD_W-1:0]       prod
);
	import bji_pkg::*;

	logic signed [MUL_A_W-1:0] a_s;
	logic signed [MUL_B_W-1:0] b_s;
	logic signed [PROD_W-1:0]  mul;
	logic signed [PROD_W-1:0]  prod_q;

	always_comb begin
		a_s = op.a;
		b_s = op.b;
		mul = PROD_W'(a_s) * PROD_W'(b_s);
	end

	always_ff @(posedge clk) begin
		prod_q <= (op.acc ? prod_q : '0) + mul;
	end

	assign prod = prod_q;
endmodule

`default_nettype wire

[rtl/bbox_jitter_injector.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbox_jitter_injector - smoothed pseudo-random jitter on a bounding box
// xorshift32 noise, low-pass filtered center offsets and size fractions
// ----------------------------------------------------------------------------
// One box per transaction on box_in, one box per transaction on box_out.
// An invisible box, or any box while jitter_on is 0, is copied through and
// leaves the noise state untouched; from acceptance it goes through S_DONE
// into the output register. A jittered box runs through a small sequencer
// around one shared multiply-accumulate unit: S_NOISE, S_OLD and S_NEW for
// each of four noise channels (draw times amplitude, old-offset weight,
// new-noise weight), S_SIZE_W and S_SIZE_H for the scaled width and height,
// S_SIZE_H and S_HGT rounding the sizes, S_EDGE forming the edges, then S_DONE
// handing the result to the output register. box_in is ready only while the
// sequencer is idle; the output register lets a result wait for box_out
// while the next box is taken. Configuration is written on cfg_we with
// cfg_index selecting jitter_on, smoothing, center_amplitude, size_amplitude
// or noise_seed; a noise_seed write also restarts the generator.
module bbox_jitter_injector (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bji_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bji_pkg::CFG_W-1:0]     cfg_wdata,
	bji_in_if.sink                             box_in,
	bji_out_if.source                          box_out
);
	import bji_pkg::*;

	// fixed point layout
	localparam int OFS_W        = 16;
	localparam int FRAC_W       = 18;
	localparam int SZ_W         = PROD_W - 11;
	localparam int CEN_W        = COORD_BITS + 5;
	localparam int EDGE_W       = SZ_W + 2;
	localparam int CENTER_SHIFT = 20;
	localparam int SIZE_SHIFT   = 24;
	localparam int SMOOTH_SHIFT = 8;
	localparam int SCALE_SHIFT  = 12;
	localparam int EDGE_SHIFT   = 5;
	localparam int SMOOTH_MAX   = 253;
	localparam int FRAC_LIMIT   = 58982;
	localparam int FRAC_ONE     = 65536;
	localparam int MIN_SIZE     = 512;
	localparam logic signed [EDGE_W-1:0] EDGE_MAX = EDGE_W'((2 ** (COORD_BITS - 1)) - 1);
	localparam logic signed [EDGE_W-1:0] EDGE_MIN = EDGE_W'(-(2 ** (COORD_BITS - 1)));

	typedef enum logic [3:0] {
		S_IDLE,
		S_NOISE,
		S_OLD,
		S_NEW,
		S_SIZE_W,
		S_SIZE_H,
		S_HGT,
		S_EDGE,
		S_DONE
	} state_t;

	// floor((x + 2^(k-1)) / 2^k)
	function automatic logic signed [PROD_W-1:0] rnd_sh(
		input logic signed [PROD_W-1:0] x,
		input int                       k
	);
		logic signed [PROD_W-1:0] half;
		half = PROD_W'(1) <<< (k - 1);
		return (x + half) >>> k;
	endfunction

	// size in 1/256 px from the span product, floored at 2 px
	function automatic logic signed [SZ_W-1:0] size_of(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] s;
		s = rnd_sh(p, SCALE_SHIFT);
		if (s < PROD_W'(MIN_SIZE)) begin
			s = PROD_W'(MIN_SIZE);
		end
		return s[SZ_W-1:0];
	endfunction

	// edge = sat(rnd((2C -/+ size) / 32))
	function automatic coord_t edge_of(
		input logic signed [CEN_W-1:0] c,
		input logic signed [SZ_W-1:0]  sz,
		input logic                    plus
	);
		logic signed [EDGE_W-1:0] e;
		logic signed [EDGE_W-1:0] q;
		logic signed [EDGE_W-1:0] half;
		half = EDGE_W'(1) <<< (EDGE_SHIFT - 1);
		e = plus ? (EDGE_W'(c) <<< 1) + EDGE_W'(sz) : (EDGE_W'(c) <<< 1) - EDGE_W'(sz);
		q = (e + half) >>> EDGE_SHIFT;
		if (q > EDGE_MAX) begin
			q = EDGE_MAX;
		end else if (q < EDGE_MIN) begin
			q = EDGE_MIN;
		end
		return coord_t'(q[COORD_BITS-1:0]);
	endfunction

	// clamp a size fraction to +-0.9 and add one
	function automatic logic signed [MUL_B_W-1:0] scale_of(
		input logic signed [FRAC_W-1:0] f
	);
		logic signed [FRAC_W-1:0] fc;
		fc = f;
		if (f > FRAC_W'(FRAC_LIMIT)) begin
			fc = FRAC_W'(FRAC_LIMIT);
		end else if (f < FRAC_W'(-FRAC_LIMIT)) begin
			fc = FRAC_W'(-FRAC_LIMIT);
		end
		return MUL_B_W'(fc) + MUL_B_W'(FRAC_ONE);
	endfunction

	// config registers
	logic                 jit_on_q;
	logic [7:0]           smooth_q;
	logic [9:0]           camp_q;
	logic [15:0]          samp_q;

	// sequencer
	state_t               st_q;
	logic [1:0]           ch_q;

	// box under work; edges are overwritten with the jittered result
	coord_t               l_q;
	coord_t               r_q;
	coord_t               t_q;
	coord_t               b_q;
	logic                 vis_q;

	// noise state
	logic signed [OFS_W-1:0]  off_u_q;
	logic signed [OFS_W-1:0]  off_v_q;
	logic signed [FRAC_W-1:0] wfrac_q;
	logic signed [FRAC_W-1:0] hfrac_q;

	// intermediate values
	logic signed [FRAC_W-1:0] n_q;
	logic signed [SZ_W-1:0]   w_q;
	logic signed [SZ_W-1:0]   h_q;

	// output register
	logic                 ov_q;
	coord_t               o_l_q;
	coord_t               o_r_q;
	coord_t               o_t_q;
	coord_t               o_b_q;
	logic                 o_vis_q;

	// datapath
	logic                        in_acc;
	logic                        seed_load;
	logic signed [DRAW_W-1:0]    draw;
	logic [GEN_W-1:0]            gen;
	logic signed [PROD_W-1:0]    prod;
	mac_op_t                     mac_op;
	logic [7:0]                  a_coef;
	logic [8:0]                  new_coef;
	logic signed [FRAC_W-1:0]    old_sel;
	logic [15:0]                 amp_sel;
	logic signed [PROD_W-1:0]    n_rnd;
	logic signed [PROD_W-1:0]    sm_rnd;
	logic                        wb_en;
	logic [1:0]                  wb_ch;
	logic signed [COORD_BITS:0]  span;
	logic signed [FRAC_W-1:0]    frac_sel;
	logic signed [CEN_W-1:0]     cu;
	logic signed [CEN_W-1:0]     cv;

	assign in_acc       = box_in.valid && box_in.ready;
	assign box_in.ready = (st_q == S_IDLE);
	assign seed_load    = cfg_we && (cfg_index == REG_NOISE_SEED);

	bji_rng u_rng (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (seed_load),
		.seed   (cfg_wdata[GEN_W-1:0]),
		.step   (st_q == S_NOISE),
		.draw   (draw),
		.gen    (gen)
	);

	bji_mul u_mul (
		.clk  (clk),
		.op   (mac_op),
		.prod (prod)
	);

	always_comb begin
		// smoothing weight saturates at 0.99
		a_coef   = (smooth_q > 8'(SMOOTH_MAX)) ? 8'(SMOOTH_MAX) : smooth_q;
		new_coef = 9'd256 - {1'b0, a_coef};

		// channels: center u, center v, width, height
		case (ch_q)
			2'd0:    old_sel = FRAC_W'(off_u_q);
			2'd1:    old_sel = FRAC_W'(off_v_q);
			2'd2:    old_sel = wfrac_q;
			default: old_sel = hfrac_q;
		endcase
		amp_sel = ch_q[1] ? samp_q : 16'(camp_q);
		n_rnd   = rnd_sh(prod, ch_q[1] ? SIZE_SHIFT : CENTER_SHIFT);
		sm_rnd  = rnd_sh(prod, SMOOTH_SHIFT);

		// the filtered value is written back in the state after its last multiply
		wb_en = ((st_q == S_NOISE) && (ch_q != 2'd0)) || (st_q == S_SIZE_W);
		wb_ch = ch_q - 2'd1;

		if (st_q == S_SIZE_W) begin
			span     = (COORD_BITS + 1)'(r_q) - (COORD_BITS + 1)'(l_q);
			frac_sel = wfrac_q;
		end else begin
			span     = (COORD_BITS + 1)'(b_q) - (COORD_BITS + 1)'(t_q);
			frac_sel = hfrac_q;
		end

		// centers in 1/256 px
		cu = ((CEN_W'(l_q) + CEN_W'(r_q)) <<< 3) + CEN_W'(off_u_q);
		cv = ((CEN_W'(t_q) + CEN_W'(b_q)) <<< 3) + CEN_W'(off_v_q);

		mac_op.a   = '0;
		mac_op.b   = '0;
		mac_op.acc = 1'b0;
		case (st_q)
			S_NOISE: begin
				mac_op.a = MUL_A_W'(draw);
				mac_op.b = MUL_B_W'(amp_sel);
			end
			S_OLD: begin
				mac_op.a = MUL_A_W'(a_coef);
				mac_op.b = MUL_B_W'(old_sel);
			end
			S_NEW: begin
				mac_op.a   = MUL_A_W'(new_coef);
				mac_op.b   = MUL_B_W'(n_q);
				mac_op.acc = 1'b1;
			end
			S_SIZE_W, S_SIZE_H: begin
				mac_op.a = MUL_A_W'(span);
				mac_op.b = scale_of(frac_sel);
			end
			default: begin
				mac_op.a = '0;
			end
		endcase
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jit_on_q <= 1'b0;
			smooth_q <= '0;
			camp_q   <= '0;
			samp_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_JITTER_ON:  jit_on_q <= cfg_wdata[0];
				REG_SMOOTHING:  smooth_q <= cfg_wdata[7:0];
				REG_CENTER_AMP: camp_q   <= cfg_wdata[9:0];
				REG_SIZE_AMP:   samp_q   <= cfg_wdata[15:0];
				default:        jit_on_q <= jit_on_q;
			endcase
		end
	end

	// noise state writeback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_u_q <= '0;
			off_v_q <= '0;
			wfrac_q <= '0;
			hfrac_q <= '0;
		end else if (wb_en) begin
			case (wb_ch)
				2'd0:    off_u_q <= sm_rnd[OFS_W-1:0];
				2'd1:    off_v_q <= sm_rnd[OFS_W-1:0];
				2'd2:    wfrac_q <= sm_rnd[FRAC_W-1:0];
				default: hfrac_q <= sm_rnd[FRAC_W-1:0];
			endcase
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ch_q <= '0;
			ov_q <= 1'b0;
		end else begin
			// a reload in S_DONE keeps the flag set instead
			if (ov_q && box_out.ready && (st_q != S_DONE)) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						l_q   <= box_in.in_left;
						r_q   <= box_in.in_right;
						t_q   <= box_in.in_top;
						b_q   <= box_in.in_bottom;
						vis_q <= box_in.in_visible;
						ch_q  <= '0;
						// passthrough skips the noise entirely
						st_q  <= (box_in.in_visible && jit_on_q) ? S_NOISE : S_DONE;
					end
				end
				S_NOISE: st_q <= S_OLD;
				S_OLD: begin
					n_q  <= n_rnd[FRAC_W-1:0];
					st_q <= S_NEW;
				end
				S_NEW: begin
					ch_q <= ch_q + 2'd1;
					st_q <= (ch_q == 2'd3) ? S_SIZE_W : S_NOISE;
				end
				S_SIZE_W: st_q <= S_SIZE_H;
				S_SIZE_H: begin
					w_q  <= size_of(prod);
					st_q <= S_HGT;
				end
				S_HGT: begin
					h_q  <= size_of(prod);
					st_q <= S_EDGE;
				end
				S_EDGE: begin
					l_q  <= edge_of(cu, w_q, 1'b0);
					r_q  <= edge_of(cu, w_q, 1'b1);
					t_q  <= edge_of(cv, h_q, 1'b0);
					b_q  <= edge_of(cv, h_q, 1'b1);
					st_q <= S_DONE;
				end
				S_DONE: begin
					// wait for the output register to free up
					if (!ov_q || box_out.ready) begin
						o_l_q   <= l_q;
						o_r_q   <= r_q;
						o_t_q   <= t_q;
						o_b_q   <= b_q;
						o_vis_q <= vis_q;
						ov_q    <= 1'b1;
						st_q    <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign box_out.valid       = ov_q;
	assign box_out.out_left    = o_l_q;
	assign box_out.out_right   = o_r_q;
	assign box_out.out_top     = o_t_q;
	assign box_out.out_bottom  = o_b_q;
	assign box_out.out_visible = o_vis_q;

	// the generator only advances while a noise channel is being drawn
	a_gen_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE && !cfg_we) |=> $stable(gen))
		else $error("noise generator moved while idle");

	// both sizes respect the 2 px floor when the edges are formed
	a_min_size: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_EDGE) |-> (w_q >= SZ_W'(MIN_SIZE) && h_q >= SZ_W'(MIN_SIZE)))
		else $error("scaled size below floor");

	// all four channels are done before the size multiplies start
	a_ch_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SIZE_W) |-> (ch_q == 2'd0 && $past(st_q) == S_NEW))
		else $error("size step entered with channels pending");

endmodule

`default_nettype wire

[verif/tb_bbox_jitter_injector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bbox_jitter_injector - self-checking bench for the box jitter injector
// A table of directed boxes and register writes runs first. Randomized
// register phases with random boxes follow. Every output box is compared
// field by field against a bit-accurate software copy of the xorshift
// generator, the low-pass filter and the box arithmetic.
// ----------------------------------------------------------------------------
module tb_bbox_jitter_injector;
	import bji_pkg::*;

	localparam int QUIET_LIMIT   = 2000;   // cycles with no transaction on either side
	localparam int DRAIN_CYCLES  = 20;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_BOXES   = 75;
	localparam int IDLE_PCT      = 22;
	localparam int STEADY_PHASE  = 3;      // phase run with no idling on either side

	localparam longint SMOOTH_CEIL = 253;
	localparam longint FRAC_LIMIT  = 58982;
	localparam longint MIN_SPAN    = 512;  // 2 px in 1/256 px

	typedef struct packed {
		coord_t left;
		coord_t right;
		coord_t top;
		coord_t bottom;
		logic   visible;
	} box_t;

	// directed table rows: a box checked by the model, a box whose copy is
	// the expected result, or a register write
	typedef enum logic [1:0] {ROW_BOX, ROW_PASS, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		box_t                 box;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     val;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	bji_in_if  box_in ();
	bji_out_if box_out ();

	bbox_jitter_injector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.box_in    (box_in),
		.box_out   (box_out)
	);

	// ------------------------------------------------------------------
	// software copy of the jitter state and registers
	// ------------------------------------------------------------------
	logic               jit_on;
	logic [7:0]         smooth_w;
	logic [9:0]         ctr_amp;
	logic [15:0]        scale_amp;
	logic [31:0]        gen_word;
	logic signed [15:0] off_u;     // 1/256 px
	logic signed [15:0] off_v;
	logic signed [17:0] frac_w;    // 1/65536
	logic signed [17:0] frac_h;

	box_t pending_boxes[$];        // expected output boxes, oldest first

	bit steady;                    // suppresses idling on both sides
	int mismatches;
	int boxes_sent;
	int boxes_seen;
	int reg_writes;
	int quiet_cycles;

	function automatic void model_reset();
		jit_on    = 1'b0;
		smooth_w  = '0;
		ctr_amp   = '0;
		scale_amp = '0;
		gen_word  = 32'd1;
		off_u     = '0;
		off_v     = '0;
		frac_w    = '0;
		frac_h    = '0;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		case (idx)
			REG_JITTER_ON:  jit_on = val[0];
			REG_SMOOTHING:  smooth_w = val[7:0];
			REG_CENTER_AMP: ctr_amp = val[9:0];
			REG_SIZE_AMP:   scale_amp = val[15:0];
			// a seed write restarts the generator as well
			REG_NOISE_SEED: gen_word = val[31:0];
			default: ;
		endcase
	endfunction

	// floor((x + 2^(k-1)) / 2^k): halves round up
	function automatic longint round_shift(longint x, int k);
		return (x + (longint'(1) <<< (k - 1))) >>> k;
	endfunction

	// one xorshift32 step, low 24 bits mapped to a signed draw around zero
	function automatic longint next_draw();
		gen_word = gen_word ^ (gen_word << 13);
		gen_word = gen_word ^ (gen_word >> 17);
		gen_word = gen_word ^ (gen_word << 5);
		return 2 * longint'(gen_word[23:0]) - longint'(24'hFFFFFF);
	endfunction

	function automatic longint low_pass(longint old_val, longint noise);
		longint a;
		a = (smooth_w > SMOOTH_CEIL) ? SMOOTH_CEIL : longint'(smooth_w);
		return round_shift(a * old_val + (256 - a) * noise, 8);
	endfunction

	// span in 1/16 px, result in 1/256 px with the 2 px floor
	function automatic longint scaled_span(longint span, longint frac);
		longint f;
		longint s;
		f = (frac > FRAC_LIMIT) ? FRAC_LIMIT : ((frac < -FRAC_LIMIT) ? -FRAC_LIMIT : frac);
		s = round_shift(span * (65536 + f), 12);
		return (s < MIN_SPAN) ? MIN_SPAN : s;
	endfunction

	function automatic coord_t clamp_coord(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
		lo = -(longint'(1) <<< (COORD_BITS - 1));
		return coord_t'((v > hi) ? hi : ((v < lo) ? lo : v));
	endfunction

	// expected output box for one accepted input box; advances the state
	function automatic void jitter_box(input box_t b, output box_t r);
		longint l, rt, t, bt;
		longint nu, nv, nw, nh;
		longint w, h, cu, cv;
		r = b;
		// invisible boxes and jitter off are plain copies, state untouched
		if (!b.visible || !jit_on)
			return;
		l  = b.left;
		rt = b.right;
		t  = b.top;
		bt = b.bottom;
		// draw order: center u, center v, width, height
		nu = round_shift(next_draw() * longint'(ctr_amp), 20);
		nv = round_shift(next_draw() * longint'(ctr_amp), 20);
		nw = round_shift(next_draw() * longint'(scale_amp), 24);
		nh = round_shift(next_draw() * longint'(scale_amp), 24);
		off_u  = low_pass(longint'(off_u), nu);
		off_v  = low_pass(longint'(off_v), nv);
		frac_w = low_pass(longint'(frac_w), nw);
		frac_h = low_pass(longint'(frac_h), nh);
		// inverted boxes give a negative span, which the floor lifts to 2 px
		w  = scaled_span(rt - l, longint'(frac_w));
		h  = scaled_span(bt - t, longint'(frac_h));
		cu = 8 * (l + rt) + longint'(off_u);
		cv = 8 * (t + bt) + longint'(off_v);
		r.left    = clamp_coord(round_shift(2 * cu - w, 5));
		r.right   = clamp_coord(round_shift(2 * cu + w, 5));
		r.top     = clamp_coord(round_shift(2 * cv - h, 5));
		r.bottom  = clamp_coord(round_shift(2 * cv + h, 5));
		r.visible = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic plan_row_t stim_row(row_kind_t kind, int l, int r, int t, int bt, bit v);
		plan_row_t row;
		row.kind = kind;
		row.box  = '{coord_t'(l), coord_t'(r), coord_t'(t), coord_t'(bt), v};
		row.idx  = '0;
		row.val  = '0;
		return row;
	endfunction

	function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		plan_row_t row;
		row.kind = ROW_REG;
		row.box  = '0;
		row.idx  = idx;
		row.val  = val;
		return row;
	endfunction

	// coordinate at or close to either end of the signed range
	function automatic coord_t far_coord();
		case ($urandom_range(3))
			0:       return coord_t'(-65536);
			1:       return coord_t'(65535);
			2:       return coord_t'(-65536 + int'($urandom_range(255)));
			default: return coord_t'(65535 - int'($urandom_range(255)));
		endcase
	endfunction

	function automatic box_t random_box();
		box_t b;
		int   cu, cv, hu, hv;
		case ($urandom_range(9))
			0, 1: begin
				// raw bit patterns, inverted boxes included
				b.left   = coord_t'($urandom);
				b.right  = coord_t'($urandom);
				b.top    = coord_t'($urandom);
				b.bottom = coord_t'($urandom);
			end
			2: begin
				// pushes the edges into saturation
				b.left   = far_coord();
				b.right  = far_coord();
				b.top    = far_coord();
				b.bottom = far_coord();
			end
			default: begin
				// ordinary boxes, mostly small, a few spanning most of the frame
				cu = int'($urandom_range(120000)) - 60000;
				cv = int'($urandom_range(120000)) - 60000;
				hu = ($urandom_range(99) < 10) ? int'($urandom_range(65535))
				                               : int'($urandom_range(3000));
				hv = ($urandom_range(99) < 10) ? int'($urandom_range(65535))
				                               : int'($urandom_range(3000));
				b.left   = coord_t'(cu - hu);
				b.right  = coord_t'(cu + hu);
				b.top    = coord_t'(cv - hv);
				b.bottom = coord_t'(cv + hv);
			end
		endcase
		b.visible = ($urandom_range(99) < 85);
		return b;
	endfunction

	function automatic logic [CFG_W-1:0] pick_seed();
		case ($urandom_range(9))
			0:       return '0;               // generator stuck at zero
			1:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		apply_reg(idx, val);
		reg_writes++;
		@(negedge clk);
	endtask

	// one input transaction, with random idle cycles ahead of it
	task automatic send_box(input box_t b, input bit copy_through);
		box_t want;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			box_in.valid <= 1'b0;
			@(negedge clk);
		end
		box_in.valid      <= 1'b1;
		box_in.in_left    <= b.left;
		box_in.in_right   <= b.right;
		box_in.in_top     <= b.top;
		box_in.in_bottom  <= b.bottom;
		box_in.in_visible <= b.visible;
		do
			@(posedge clk);
		while (!box_in.ready);
		// the model runs even for copy rows so its state stays in step
		jitter_box(b, want);
		pending_boxes = {pending_boxes, (copy_through ? b : want)};
		boxes_sent++;
		@(negedge clk);
	endtask

	// registers only change with nothing in flight
	task automatic wait_drained();
		box_in.valid <= 1'b0;
		while (pending_boxes.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// clock, output side, watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// output stalls, except during the steady phase
	always @(negedge clk) begin
		box_out.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// every output transaction against the oldest expected box
	always @(posedge clk) begin : box_check
		box_t want;
		if (arst_n && box_out.valid && box_out.ready) begin
			boxes_seen++;
			if (pending_boxes.size() == 0) begin
				$display("%0t: unexpected output box, expected none, actual %0d %0d %0d %0d %0d",
					$time, box_out.out_left, box_out.out_right, box_out.out_top,
					box_out.out_bottom, box_out.out_visible);
				mismatches++;
			end else begin
				want = pending_boxes.pop_front();
				check_field("out_left", want.left, box_out.out_left);
				check_field("out_right", want.right, box_out.out_right);
				check_field("out_top", want.top, box_out.out_top);
				check_field("out_bottom", want.bottom, box_out.out_bottom);
				check_field("out_visible", want.visible, box_out.out_visible);
			end
		end
	end

	// a hang shows up as a long run with no transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (box_in.valid && box_in.ready) || (box_out.valid && box_out.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d boxes still expected",
					$time, quiet_cycles, pending_boxes.size());
				$display("simulation failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		plan_row_t plan[$];
		int        phase;

		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_wdata         = '0;
		box_in.valid      = 1'b0;
		box_in.in_left    = '0;
		box_in.in_right   = '0;
		box_in.in_top     = '0;
		box_in.in_bottom  = '0;
		box_in.in_visible = 1'b0;
		box_out.ready     = 1'b0;
		steady            = 1'b0;
		mismatches        = 0;
		boxes_sent        = 0;
		boxes_seen        = 0;
		reg_writes        = 0;
		quiet_cycles      = 0;
		model_reset();

		// jitter is off after reset: every box comes back as it went in
		plan = {plan, stim_row(ROW_PASS, -65536, 65535, -65536, 65535, 1'b1)};
		plan = {plan, stim_row(ROW_PASS, 65535, -65536, 65535, -65536, 1'b1)};
		plan = {plan, stim_row(ROW_PASS, 0, 0, 0, 0, 1'b0)};
		plan = {plan, stim_row(ROW_PASS, -1, -1, -1, -1, 1'b1)};
		plan = {plan, stim_row(ROW_PASS, 21845, -21846, 43690, -43691, 1'b0)};
		// full noise on both amplitudes, no smoothing
		plan = {plan, reg_row(REG_JITTER_ON, 32'd1)};
		plan = {plan, reg_row(REG_SMOOTHING, 32'd0)};
		plan = {plan, reg_row(REG_CENTER_AMP, 32'd1023)};
		plan = {plan, reg_row(REG_SIZE_AMP, 32'd65535)};
		plan = {plan, reg_row(REG_NOISE_SEED, 32'd1)};
		plan = {plan, stim_row(ROW_BOX, 1600, 3200, 800, 2400, 1'b1)};
		plan = {plan, stim_row(ROW_BOX, 3200, 1600, 2400, 800, 1'b1)};      // inverted box
		plan = {plan, stim_row(ROW_BOX, 100, 100, 100, 100, 1'b1)};         // zero size
		plan = {plan, stim_row(ROW_BOX, -65536, 65535, -65536, 65535, 1'b1)}; // overflow
		plan = {plan, stim_row(ROW_BOX, 60000, 65535, -65536, -60000, 1'b1)};
		// invisible while jitter is on is still a plain copy
		plan = {plan, stim_row(ROW_PASS, 1000, 2000, 1000, 2000, 1'b0)};
		plan = {plan, stim_row(ROW_BOX, -2000, -1000, -500, 500, 1'b1)};
		// zero seed: every draw is the most negative value, filtered under the smoothing ceiling
		plan = {plan, reg_row(REG_SMOOTHING, 32'd255)};
		plan = {plan, reg_row(REG_NOISE_SEED, 32'd0)};
		plan = {plan, stim_row(ROW_BOX, 1600, 3200, 800, 2400, 1'b1)};
		plan = {plan, stim_row(ROW_BOX, 1600, 3200, 800, 2400, 1'b1)};
		plan = {plan, stim_row(ROW_BOX, 0, 16, 0, 16, 1'b1)};
		// zero amplitudes with all-ones seed
		plan = {plan, reg_row(REG_SMOOTHING, 32'd253)};
		plan = {plan, reg_row(REG_CENTER_AMP, 32'd0)};
		plan = {plan, reg_row(REG_SIZE_AMP, 32'd0)};
		plan = {plan, reg_row(REG_NOISE_SEED, 32'hFFFF_FFFF)};
		plan = {plan, stim_row(ROW_BOX, -4000, 4000, -3000, 3000, 1'b1)};
		plan = {plan, stim_row(ROW_BOX, 500, 900, 700, 1200, 1'b1)};
		plan = {plan, reg_row(REG_JITTER_ON, 32'd0)};
		plan = {plan, stim_row(ROW_PASS, -65536, 65535, 0, 0, 1'b1)};
		// mid settings
		plan = {plan, reg_row(REG_SMOOTHING, 32'd128)};
		plan = {plan, reg_row(REG_CENTER_AMP, 32'd640)};
		plan = {plan, reg_row(REG_SIZE_AMP, 32'd32768)};
		plan = {plan, reg_row(REG_NOISE_SEED, 32'h1234_5678)};
		plan = {plan, reg_row(REG_JITTER_ON, 32'd1)};
		plan = {plan, stim_row(ROW_BOX, 1600, 3200, 800, 2400, 1'b1)};
		plan = {plan, stim_row(ROW_BOX, -30000, 30000, -100, 100, 1'b1)};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				wait_drained();
				reg_write(plan[i].idx, plan[i].val);
			end else begin
				cfg_we <= 1'b0;
				send_box(plan[i].box, plan[i].kind == ROW_PASS);
			end
		end

		// random register settings per phase, random boxes within
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_drained();
			steady = (phase == STEADY_PHASE);
			reg_write(REG_JITTER_ON, ($urandom_range(99) < 85) ? 32'd1 : 32'd0);
			case ($urandom_range(4))
				0:       reg_write(REG_SMOOTHING, 32'd0);
				1:       reg_write(REG_SMOOTHING, 32'd253);
				2:       reg_write(REG_SMOOTHING, $urandom_range(255, 254)); // above ceiling
				default: reg_write(REG_SMOOTHING, $urandom_range(255));
			endcase
			case ($urandom_range(3))
				0:       reg_write(REG_CENTER_AMP, 32'd0);
				1:       reg_write(REG_CENTER_AMP, 32'd1023);
				default: reg_write(REG_CENTER_AMP, $urandom_range(1023));
			endcase
			case ($urandom_range(4))
				0:       reg_write(REG_SIZE_AMP, 32'd0);
				1:       reg_write(REG_SIZE_AMP, 32'd65535);
				2:       reg_write(REG_SIZE_AMP, 32'd32768);
				default: reg_write(REG_SIZE_AMP, $urandom_range(65535));
			endcase
			// on average half the phases keep the running generator
			if ($urandom_range(1))
				reg_write(REG_NOISE_SEED, pick_seed());
			cfg_we <= 1'b0;
			repeat (PHASE_BOXES)
				send_box(random_box(), 1'b0);
		end

		wait_drained();
		steady = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("boxes driven %0d, boxes checked %0d, register writes %0d over %0d random phases",
			boxes_sent, boxes_seen, reg_writes, RANDOM_PHASES);
		$display("covered copy-through, jitter at amplitude and smoothing extremes, zero seed,"
			, " inverted and saturating boxes");
		if (mismatches == 0 && pending_boxes.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[bbox_jitter_injector.f]
rtl/bji_pkg.sv
rtl/bji_if.sv
rtl/bji_rng.sv
rtl/bji_mul.sv
rtl/bbox_jitter_injector.sv
verif/tb_bbox_jitter_injector.sv
